// ===== src/radio_header_sync_extractor_core_macros.svh =====
// ----------------------------------------------------------------------------
// radio_header_sync_extractor_core_macros.svh
// Assertion macros for the header sync extractor.
// ----------------------------------------------------------------------------
`ifndef RADIO_HEADER_SYNC_EXTRACTOR_CORE_MACROS_SVH
`define RADIO_HEADER_SYNC_EXTRACTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, masked while reset is high
`define RHSE_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rhse assertion failed");

// clocked check, also active during reset
`define RHSE_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("rhse assertion failed");

`else

`define RHSE_ASSERT(name, clk, rst, prop)
`define RHSE_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== src/rhse_pkg.sv =====
// ----------------------------------------------------------------------------
// rhse_pkg
// Shared constants and types for the header sync extractor.
// ----------------------------------------------------------------------------
package rhse_pkg;

   localparam int SEARCH_WINDOW_DEF    = 20;
   localparam int MIN_HEADER_BYTES_DEF = 16;
   localparam int MAX_PACKET_BYTES_DEF = 256;

   localparam int CNT_W  = 9;   // byte count, holds up to 256
   localparam int OFF_W  = 5;   // header start
   localparam int RUN_W  = 3;   // 0xFF run length, saturates at SYNC_RUN

   localparam logic [7:0]       SYNC_BYTE = 8'hFF;
   localparam logic [RUN_W-1:0] SYNC_RUN  = 3'd4;
   localparam logic [31:0]      DEST_BCAST = 32'hFFFF_FFFF;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] offset;
      logic [CNT_W-1:0] payload_length;
      logic [31:0]      dest_id;
      logic [31:0]      node_id;
      logic [31:0]      packet_id;
      logic [2:0]       hop_count;
      logic             want_ack;
      logic             via_gateway;
      logic [1:0]       priority_res;
      logic [7:0]       channel;
   } rsp_fields_type;

endpackage

// ===== src/radio_header_sync_extractor_core.sv =====
// ----------------------------------------------------------------------------
// radio_header_sync_extractor_core
// Finds a four-0xFF header in a byte stream and extracts its fields.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle on req_ and returns one word on rsp_ for
// every byte marked tlast. Throughput is one byte per clock: the byte goes
// into an input register, the match and field capture logic updates the
// per-packet state and, on the last byte, loads the result register. A
// new byte is taken while a result waits; only a last byte stalls, and
// only while the result register is still full. Bytes past
// MAX_PACKET_BYTES are dropped except for their last mark.
// ----------------------------------------------------------------------------
`include "radio_header_sync_extractor_core_macros.svh"

module radio_header_sync_extractor_core
   import rhse_pkg::*;
#(
   parameter int SEARCH_WINDOW    = SEARCH_WINDOW_DEF,
   parameter int MIN_HEADER_BYTES = MIN_HEADER_BYTES_DEF,
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] data_byte
   input  logic         req_tlast,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [4:0] offset, [13:5] payload_length, [45:14] dest_id, [77:46] node_id,
   // [109:78] packet_id, [112:110] hop_count, [113] want_ack,
   // [114] via_gateway, [116:115] priority_res, [124:117] channel, rest 0
   output logic [127:0] rsp_tdata,
   output logic         rsp_tuser     // [0] found
);

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   // per-packet state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             first_ff, first_in;
   logic             locked_ff, locked_in;
   logic [OFF_W-1:0] start_ff, start_in;
   logic [31:0]      source_ff, source_in;
   logic [31:0]      pkt_ff, pkt_in;
   logic [7:0]       flags_ff, flags_in;
   logic [7:0]       chan_ff, chan_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_fields_type   rsp_ff, rsp_in;

   logic             proc;
   logic             take;
   logic             is_sync;
   logic [CNT_W-1:0] cand;
   logic [CNT_W-1:0] rel;
   logic [CNT_W-1:0] span;
   logic             found;

   // a last byte needs room in the result register, other bytes never wait
   assign proc = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   assign take    = count_ff < CNT_W'(MAX_PACKET_BYTES);
   assign is_sync = in_byte_ff == SYNC_BYTE;
   assign cand    = count_ff - CNT_W'(SYNC_RUN - 3'd1);
   assign rel     = count_ff - CNT_W'(start_ff);

   always_comb begin
      count_in  = count_ff;
      run_in    = run_ff;
      first_in  = first_ff;
      locked_in = locked_ff;
      start_in  = start_ff;
      source_in = source_ff;
      pkt_in    = pkt_ff;
      flags_in  = flags_ff;
      chan_in   = chan_ff;
      if (take) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == '0 && is_sync) begin
            first_in = 1'b1;
         end
         if (!is_sync) begin
            run_in = '0;
         end else if (run_ff < SYNC_RUN) begin
            run_in = run_ff + RUN_W'(1);
         end
         if (locked_ff) begin
            if (rel inside {[9'd4:9'd7]}) begin
               source_in[8*rel[1:0] +: 8] = in_byte_ff;
            end else if (rel inside {[9'd8:9'd11]}) begin
               pkt_in[8*rel[1:0] +: 8] = in_byte_ff;
            end else if (rel == 9'd12) begin
               flags_in = in_byte_ff;
            end else if (rel == 9'd13) begin
               chan_in = in_byte_ff;
            end
         end else if (is_sync && run_in == SYNC_RUN &&
                      count_ff >= CNT_W'(SYNC_RUN - 3'd1)) begin
            if (cand < CNT_W'(SEARCH_WINDOW) && (!first_in || cand == '0)) begin
               locked_in = 1'b1;
               start_in  = cand[OFF_W-1:0];
            end
         end
      end
   end

   assign span  = count_in - CNT_W'(start_in);
   assign found = locked_in && span >= CNT_W'(MIN_HEADER_BYTES);

   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_tready;
      if (proc && in_last_ff) begin
         rsp_valid_in          = 1'b1;
         rsp_in.found          = found;
         rsp_in.offset         = found ? start_in : '0;
         rsp_in.payload_length = found ? span : count_in;
         rsp_in.dest_id        = DEST_BCAST;
         rsp_in.node_id        = found ? source_in : '0;
         rsp_in.packet_id      = found ? pkt_in : '0;
         rsp_in.hop_count      = found ? flags_in[2:0] : '0;
         rsp_in.want_ack       = found && flags_in[3];
         rsp_in.via_gateway    = found && flags_in[4];
         rsp_in.priority_res   = found ? flags_in[6:5] : '0;
         rsp_in.channel        = found ? chan_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      rsp_ff <= rsp_in;
   end

   // packet state returns to zero after each last byte
   always_ff @(posedge clock) begin
      if (reset || (proc && in_last_ff)) begin
         count_ff  <= '0;
         run_ff    <= '0;
         first_ff  <= 1'b0;
         locked_ff <= 1'b0;
         start_ff  <= '0;
         source_ff <= '0;
         pkt_ff    <= '0;
         flags_ff  <= '0;
         chan_ff   <= '0;
      end else if (proc) begin
         count_ff  <= count_in;
         run_ff    <= run_in;
         first_ff  <= first_in;
         locked_ff <= locked_in;
         start_ff  <= start_in;
         source_ff <= source_in;
         pkt_ff    <= pkt_in;
         flags_ff  <= flags_in;
         chan_ff   <= chan_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.found;
   assign rsp_tdata  = {3'b000, rsp_ff.channel, rsp_ff.priority_res, rsp_ff.via_gateway,
                        rsp_ff.want_ack, rsp_ff.hop_count, rsp_ff.packet_id,
                        rsp_ff.node_id, rsp_ff.dest_id, rsp_ff.payload_length,
                        rsp_ff.offset};

   `RHSE_ASSERT(a_found_in_window, clock, reset,
      rsp_valid_ff && rsp_ff.found |-> CNT_W'(rsp_ff.offset) < CNT_W'(SEARCH_WINDOW))
   `RHSE_ASSERT(a_found_len, clock, reset,
      rsp_valid_ff && rsp_ff.found |->
         rsp_ff.payload_length >= CNT_W'(MIN_HEADER_BYTES))
   `RHSE_ASSERT(a_miss_zero, clock, reset,
      rsp_valid_ff && !rsp_ff.found |->
         rsp_ff.offset == '0 && rsp_ff.node_id == '0 && rsp_ff.channel == '0)
   `RHSE_ASSERT(a_lock_behind, clock, reset,
      locked_ff |-> count_ff >= CNT_W'(start_ff) + CNT_W'(SYNC_RUN))
   `RHSE_ASSERT_ALWAYS(a_clear_after_last, clock,
      proc && in_last_ff |=> !locked_ff && count_ff == '0)

endmodule
